// ===== rtl/core/tiled_heightfield_bilinear_sampler_core_defines.svh =====
// Assertion macros for the sampler RTL.
`ifndef TILED_HEIGHTFIELD_BILINEAR_SAMPLER_CORE_DEFINES_SVH
`define TILED_HEIGHTFIELD_BILINEAR_SAMPLER_CORE_DEFINES_SVH

// Checks that cond_b holds in the same cycle as cond_a.
`define THBS_ASSERT_SAME(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error(msg);

// Checks that cond_b holds in the cycle after cond_a.
`define THBS_ASSERT_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error(msg);

`endif

// ===== rtl/core/thbs_pkg.sv =====
// Shared types, codes and pipeline constants of the heightfield sampler.
`timescale 1ns / 1ps
`default_nettype none
package thbs_pkg;

  localparam int DEF_GRID_COLS = 128;
  localparam int DEF_GRID_ROWS = 128;
  localparam int DEF_MAX_CONES = 4;

  localparam int TILE_STEPS = 5;
  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = 16;
  localparam int GRID_LAT   = 6 + TILE_STEPS;
  localparam int CONE_LAT   = 5 + SQRT_STEPS + DIV_STEPS;
  localparam int GRID_DLY   = CONE_LAT - GRID_LAT;

  localparam logic [1:0] KIND_GRID_WR = 2'd0;
  localparam logic [1:0] KIND_CONE_WR = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  localparam logic [1:0] REG_REPEAT_X = 2'd0;
  localparam logic [1:0] REG_REPEAT_Z = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Z = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [14:0]        sample_index;
    logic signed [15:0] sample_height;
    logic [1:0]         cone_slot;
    logic signed [19:0] cone_center_x;
    logic signed [19:0] cone_center_z;
    logic [15:0]        cone_radius;
    logic signed [15:0] cone_peak;
    logic signed [19:0] query_x;
    logic signed [19:0] query_z;
  } req_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic               in_range;
  } rsp_t;

  typedef struct packed {
    logic signed [19:0] cx;
    logic signed [19:0] cz;
    logic [15:0]        radius;
    logic signed [15:0] peak;
  } cone_t;

  typedef struct packed {
    logic [4:0]         repeat_x;
    logic [4:0]         repeat_z;
    logic signed [19:0] origin_x;
    logic signed [19:0] origin_z;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/thbs_chan_if.sv =====
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
`default_nettype none
interface thbs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/thbs_grid.sv =====
// Tile location, corner fetch and bilinear interpolation pipeline.
`timescale 1ns / 1ps
`default_nettype none
module thbs_grid import thbs_pkg::*; #(
  parameter int GRID_COLS = DEF_GRID_COLS,
  parameter int GRID_ROWS = DEF_GRID_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               wr,
  input  wire logic [14:0]        sample_index,
  input  wire logic signed [15:0] sample_height,
  input  wire logic signed [19:0] query_x,
  input  wire logic signed [19:0] query_z,
  input  wire cfg_t               cfg,
  output logic signed [15:0]      height,
  output logic                    in_range
);

  localparam int VPR        = GRID_COLS + 1;
  localparam int VERT_TOTAL = VPR * (GRID_ROWS + 1);
  localparam int AW         = $clog2(VERT_TOTAL);
  localparam int CXW        = $clog2(GRID_COLS);
  localparam int CZW        = $clog2(GRID_ROWS);
  localparam int WR_STAGES  = 3 + TILE_STEPS;
  localparam logic [20:0]   TILE_X = 21'(GRID_COLS * 256);
  localparam logic [20:0]   TILE_Z = 21'(GRID_ROWS * 256);
  localparam logic [AW-1:0] VPR_A  = AW'(VPR);

  // Height writes travel with the queries so that both reach the store in order.
  logic [WR_STAGES-1:0] wv;
  logic [AW-1:0]        widx [0:WR_STAGES-1];
  logic signed [15:0]   whgt [0:WR_STAGES-1];

  logic signed [20:0] lx, lz;
  logic [20:0]        lim_x, lim_z;
  logic [20:0]        rx [0:TILE_STEPS];
  logic [20:0]        rz [0:TILE_STEPS];
  logic               rs [0:TILE_STEPS];

  logic [CXW-1:0]     ix;
  logic [CZW-1:0]     iz;
  logic [AW-1:0]      v0, a2;
  logic [7:0]         fx8, fz8, fx9, fz9, fz10;
  logic               rng8, rng9, rng10;
  logic signed [15:0] d00, d01, d10, d11;
  logic signed [9:0]  wx0, wx1, wz0, wz1;
  logic signed [25:0] h0, h1;
  logic signed [35:0] hsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= '0;
    end else if (adv) begin
      wv <= {wv[WR_STAGES-2:0], wr && (17'(sample_index) < 17'(VERT_TOTAL))};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      widx[0] <= AW'(sample_index);
      whgt[0] <= sample_height;
      for (int i = 1; i < WR_STAGES; i++) begin
        widx[i] <= widx[i-1];
        whgt[i] <= whgt[i-1];
      end
    end
  end

  always_comb begin
    lim_x = 21'(cfg.repeat_x) * TILE_X;
    lim_z = 21'(cfg.repeat_z) * TILE_Z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx    <= {query_x[19], query_x} - {cfg.origin_x[19], cfg.origin_x};
      lz    <= {query_z[19], query_z} - {cfg.origin_z[19], cfg.origin_z};
      rs[0] <= !lx[20] && !lz[20] && ($unsigned(lx) < lim_x) && ($unsigned(lz) < lim_z);
      rx[0] <= $unsigned(lx);
      rz[0] <= $unsigned(lz);
    end
  end

  // Restoring steps on the tile index leave the offset within the tile.
  for (genvar j = 0; j < TILE_STEPS; j++) begin : g_tile
    localparam logic [20:0] STEP_X = TILE_X << (TILE_STEPS - 1 - j);
    localparam logic [20:0] STEP_Z = TILE_Z << (TILE_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      if (adv) begin
        rx[j+1] <= (rx[j] >= STEP_X) ? rx[j] - STEP_X : rx[j];
        rz[j+1] <= (rz[j] >= STEP_Z) ? rz[j] - STEP_Z : rz[j];
        rs[j+1] <= rs[j];
      end
    end
  end

  assign ix = rx[TILE_STEPS][CXW+7:8];
  assign iz = rz[TILE_STEPS][CZW+7:8];

  always_ff @(posedge clk) begin
    if (adv) begin
      v0   <= AW'(ix) + AW'(iz) * VPR_A;
      fx8  <= rx[TILE_STEPS][7:0];
      fz8  <= rz[TILE_STEPS][7:0];
      rng8 <= rs[TILE_STEPS];
    end
  end

  assign a2 = v0 + VPR_A;

  // Two copies of the store, each read at two corners of the cell.
  logic signed [15:0] mem_a [0:VERT_TOTAL-1];
  logic signed [15:0] mem_b [0:VERT_TOTAL-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wv[WR_STAGES-1]) begin
        mem_a[widx[WR_STAGES-1]] <= whgt[WR_STAGES-1];
      end
      d00 <= mem_a[v0];
      d01 <= mem_a[v0 + AW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wv[WR_STAGES-1]) begin
        mem_b[widx[WR_STAGES-1]] <= whgt[WR_STAGES-1];
      end
      d10 <= mem_b[a2];
      d11 <= mem_b[a2 + AW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx9  <= fx8;
      fz9  <= fz8;
      rng9 <= rng8;
    end
  end

  always_comb begin
    wx1  = $signed({2'b00, fx9});
    wx0  = 10'sd256 - wx1;
    wz1  = $signed({2'b00, fz10});
    wz0  = 10'sd256 - wz1;
    hsum = 36'(h0 * wz0) + 36'(h1 * wz1) + 36'sd32768;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h0       <= 26'(d00 * wx0) + 26'(d01 * wx1);
      h1       <= 26'(d10 * wx0) + 26'(d11 * wx1);
      fz10     <= fz9;
      rng10    <= rng9;
      height   <= rng10 ? hsum[31:16] : '0;
      in_range <= rng10;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/thbs_cone.sv =====
// One cone lane: distance, integer root, scaling and division pipeline.
`timescale 1ns / 1ps
`default_nettype none
module thbs_cone import thbs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic signed [19:0] query_x,
  input  wire logic signed [19:0] query_z,
  input  wire cone_t              cone,
  output logic                    hit,
  output logic signed [15:0]      value
);

  logic signed [20:0] dx, dz;
  logic [15:0]        r1, r2;
  logic signed [15:0] pk1, pk2;
  logic [41:0]        sx, sz;
  logic [31:0]        rr;
  logic [42:0]        ssum;

  logic [18:0]        sq_rem  [0:SQRT_STEPS];
  logic [15:0]        sq_root [0:SQRT_STEPS];
  logic [31:0]        sq_src  [0:SQRT_STEPS];
  logic [15:0]        sq_r    [0:SQRT_STEPS];
  logic signed [15:0] sq_pk   [0:SQRT_STEPS];
  logic               sq_hit  [0:SQRT_STEPS];

  logic [15:0]        dv_rem [0:DIV_STEPS];
  logic [15:0]        dv_src [0:DIV_STEPS];
  logic [15:0]        dv_q   [0:DIV_STEPS];
  logic [15:0]        dv_r   [0:DIV_STEPS];
  logic               dv_neg [0:DIV_STEPS];
  logic               dv_hit [0:DIV_STEPS];

  logic [15:0]        pk_mag;
  logic [31:0]        num;

  assign ssum = {1'b0, sx} + {1'b0, sz};

  always_ff @(posedge clk) begin
    if (adv) begin
      dx         <= {query_x[19], query_x} - {cone.cx[19], cone.cx};
      dz         <= {query_z[19], query_z} - {cone.cz[19], cone.cz};
      r1         <= cone.radius;
      pk1        <= cone.peak;
      sx         <= 42'(dx * dx);
      sz         <= 42'(dz * dz);
      rr         <= r1 * r1;
      r2         <= r1;
      pk2        <= pk1;
      sq_hit[0]  <= ssum < {11'd0, rr};
      sq_src[0]  <= ssum[31:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_r[0]    <= r2;
      sq_pk[0]   <= pk2;
    end
  end

  // Digit-by-digit square root, one result bit per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [18:0] rc, trial;
    always_comb begin
      rc    = {sq_rem[k][16:0], sq_src[k][31:30]};
      trial = {1'b0, sq_root[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rc >= trial) begin
          sq_rem[k+1]  <= rc - trial;
          sq_root[k+1] <= {sq_root[k][14:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= rc;
          sq_root[k+1] <= {sq_root[k][14:0], 1'b0};
        end
        sq_src[k+1] <= {sq_src[k][29:0], 2'b00};
        sq_r[k+1]   <= sq_r[k];
        sq_pk[k+1]  <= sq_pk[k];
        sq_hit[k+1] <= sq_hit[k];
      end
    end
  end

  // The magnitude of the most negative peak still fits sixteen unsigned bits.
  assign pk_mag = sq_pk[SQRT_STEPS][15] ? 16'(-sq_pk[SQRT_STEPS]) : sq_pk[SQRT_STEPS];
  assign num    = pk_mag * (sq_r[SQRT_STEPS] - sq_root[SQRT_STEPS]);

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= num[31:16];
      dv_src[0] <= num[15:0];
      dv_q[0]   <= '0;
      dv_r[0]   <= sq_r[SQRT_STEPS];
      dv_neg[0] <= sq_pk[SQRT_STEPS][15];
      dv_hit[0] <= sq_hit[SQRT_STEPS];
    end
  end

  // Restoring division, one quotient bit per stage; for a hit the quotient never exceeds the peak's magnitude.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [16:0] rc;
    logic        take;
    always_comb begin
      rc   = {dv_rem[k], dv_src[k][15]};
      take = rc >= {1'b0, dv_r[k]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k+1] <= take ? 16'(rc - {1'b0, dv_r[k]}) : rc[15:0];
        dv_q[k+1]   <= {dv_q[k][14:0], take};
        dv_src[k+1] <= {dv_src[k][14:0], 1'b0};
        dv_r[k+1]   <= dv_r[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_hit[k+1] <= dv_hit[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit   <= dv_hit[DIV_STEPS];
      value <= dv_neg[DIV_STEPS] ? $signed(16'(-dv_q[DIV_STEPS])) : $signed(dv_q[DIV_STEPS]);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tiled_heightfield_bilinear_sampler_core.sv =====
// Top level of the tiled heightfield sampler: configuration, cone table and result merge.
//
// Usage: items enter on the req channel and results leave on rsp, both valid/ready.
// A grid write (kind 0) stores one vertex height, a cone write (kind 1) loads one
// cone table slot, and a query (kind 2) returns one beat with the height and the
// in-range flag. Writes and unknown kinds return nothing.
// Throughput is one item per cycle while rsp is not stalled. A query's result leaves
// through the merge register; the 16-stage square root and the 16-stage divider
// of the cone lanes set the pipeline depth, and the grid result is delayed to meet them.
// The user writes registers on the cfg port only while the block is idle; the block does not enforce it.
// Reset (rst, synchronous) clears all valid state, disables every cone and sets
// the repeat counts to one and the origins to zero; the height store is not cleared
// and must be written before a query reads it.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and req.ready falls in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "tiled_heightfield_bilinear_sampler_core_defines.svh"
module tiled_heightfield_bilinear_sampler_core import thbs_pkg::*; #(
  parameter int GRID_COLS = DEF_GRID_COLS,
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int MAX_CONES = DEF_MAX_CONES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [19:0] cfg_wdata,
  thbs_chan_if.sink        req,
  thbs_chan_if.source      rsp
);

  logic                adv;
  logic                accept;
  cfg_t                cfg;
  cone_t               tbl [0:MAX_CONES-1];
  logic [CONE_LAT-1:0] qv;

  logic signed [15:0]  g_h;
  logic                g_rng;
  logic signed [15:0]  dh [0:GRID_DLY-1];
  logic                dr [0:GRID_DLY-1];

  logic [MAX_CONES-1:0] c_hit;
  logic signed [15:0]   c_val [0:MAX_CONES-1];

  logic                ov;
  logic signed [15:0]  best;
  logic signed [15:0]  out_h;
  logic                out_rng;

  assign adv       = !ov || rsp.ready;
  assign accept    = req.valid && adv;
  assign req.ready = adv;
  assign rsp.valid = ov;
  assign rsp.data  = '{height: out_h, in_range: out_rng};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{repeat_x: 5'd1, repeat_z: 5'd1, origin_x: '0, origin_z: '0};
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_REPEAT_X: cfg.repeat_x <= cfg_wdata[4:0];
        REG_REPEAT_Z: cfg.repeat_z <= cfg_wdata[4:0];
        REG_ORIGIN_X: cfg.origin_x <= $signed(cfg_wdata);
        REG_ORIGIN_Z: cfg.origin_z <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Cone writes land at acceptance, where queries also take their copy of the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CONES; i++) begin
        tbl[i] <= '0;
      end
    end else if (accept && req.data.kind == KIND_CONE_WR) begin
      for (int i = 0; i < MAX_CONES; i++) begin
        if (32'(req.data.cone_slot) == i) begin
          tbl[i] <= '{cx: req.data.cone_center_x, cz: req.data.cone_center_z,
                      radius: req.data.cone_radius, peak: req.data.cone_peak};
        end
      end
    end
  end

  thbs_grid #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_grid (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .wr            (accept && req.data.kind == KIND_GRID_WR),
    .sample_index  (req.data.sample_index),
    .sample_height (req.data.sample_height),
    .query_x       (req.data.query_x),
    .query_z       (req.data.query_z),
    .cfg           (cfg),
    .height        (g_h),
    .in_range      (g_rng)
  );

  for (genvar i = 0; i < MAX_CONES; i++) begin : g_lane
    thbs_cone u_cone (
      .clk     (clk),
      .adv     (adv),
      .query_x (req.data.query_x),
      .query_z (req.data.query_z),
      .cone    (tbl[i]),
      .hit     (c_hit[i]),
      .value   (c_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= '0;
    end else if (adv) begin
      qv <= {qv[CONE_LAT-2:0], accept && req.data.kind == KIND_QUERY};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dh[0] <= g_h;
      dr[0] <= g_rng;
      for (int i = 1; i < GRID_DLY; i++) begin
        dh[i] <= dh[i-1];
        dr[i] <= dr[i-1];
      end
    end
  end

  always_comb begin
    best = dh[GRID_DLY-1];
    for (int i = 0; i < MAX_CONES; i++) begin
      if (c_hit[i] && c_val[i] > best) begin
        best = c_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= qv[CONE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_h   <= dr[GRID_DLY-1] ? best : '0;
      out_rng <= dr[GRID_DLY-1];
    end
  end

  `THBS_ASSERT_SAME(a_out_of_range_zero, ov, rsp.data.in_range || rsp.data.height == 16'sd0, "out-of-range beat carries a non-zero height")
  `THBS_ASSERT_NEXT(a_query_reaches_out, qv[CONE_LAT-1] && adv, ov, "query at the end of the pipeline was not presented")
  `THBS_ASSERT_NEXT(a_no_spurious_beat, !qv[CONE_LAT-1] && adv, !ov, "result beat without a query behind it")
  `THBS_ASSERT_NEXT(a_stall_freezes, !adv, $stable(qv), "pipeline moved while the output was stalled")

endmodule
`default_nettype wire
